[design/assert_macros.svh]
// Assertion macros shared by the design files.
// Included by files that check properties; empty bodies under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UET_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define UET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define UET_ASSERT(lbl, expr, msg)
`define UET_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[design/uetpf_pkg.sv]
// Types and codes of the edge table path finder.
// No dependencies.
package uetpf_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned VtxW   = 8;
  localparam int unsigned StatW  = 2;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned CntW   = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_DEGREE = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_PATH   = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NOPATH   = 2'd3
  } status_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DISP  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_SHIFT = 8'b0000_1000,
    S_POP   = 8'b0001_0000,
    S_EMRD  = 8'b0010_0000,
    S_EMWR  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [VtxW-1:0]  path_vertex;
    logic [CntW-1:0]  edge_count;
    logic [CntW-1:0]  degree_count;
    logic [IdxW-1:0]  edge_index;
    logic             found;
    logic [StatW-1:0] status;
  } res_t;

endpackage

[design/uet_ram.sv]
// Single-port-write, single-port-read synchronous memory, registered read.
// No dependencies.
module uet_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/undirected_edge_table_path_finder_unit.sv]
// Channel   Dir  Signals                     Payload
// s_axis    in   tvalid tready tdata[23:0]   command, vertex_a, vertex_b
// m_axis    out  tvalid tready tdata[31:0]   status..path_vertex; tlast = last
//
// Add, clear and unknown commands answer straight from dispatch. Lookup, a remove that
// misses and degree scan the edge memory one entry a cycle; a remove that matches stops
// its scan at the match and shifts the later entries up. Path search rescans from entry 0
// after every push and pop, and reads each emitted vertex back from the stack memory.
// Reset clears control state only; memories need no clearing.
// A stalled output holds the engine; a new word is accepted once the last
// result of the previous one sits in the output register.
// Depends on uetpf_pkg, uet_ram and assert_macros.svh.
`include "assert_macros.svh"
module undirected_edge_table_path_finder_unit
  import uetpf_pkg::*;
#(
  parameter int unsigned MAX_EDGES   = 32,
  parameter int unsigned VERTEX_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // command[2:0], vertex_a[10:3], vertex_b[18:11], zero fill
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], found[2], edge_index[7:3], degree_count[13:8],
  // edge_count[19:14], path_vertex[27:20], zero fill
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned IW = $clog2(MAX_EDGES);
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned SW = $clog2(MAX_EDGES + 1);
  localparam int unsigned DW = $clog2(MAX_EDGES + 2);
  localparam int unsigned VB = VERTEX_BITS;

  state_e            state_q, state_d;
  logic [CmdW-1:0]   cmd_q, cmd_d;
  logic [VB-1:0]     a_q, a_d, b_q, b_d, top_q, top_d;
  logic [CW-1:0]     held_q, held_d, scan_q, scan_d, deg_q, deg_d;
  logic              rv_q, rv_d;
  logic [IW-1:0]     ridx_q, ridx_d, mi_q, mi_d;
  logic [MAX_EDGES-1:0] used_q, used_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic [SW-1:0]     k_q, k_d;
  res_t              res_q, res_d, out_q, out_d;
  logic              ov_q, ov_d, olast_q, olast_d;

  logic              e_we, e_re, s_we, s_re;
  logic [IW-1:0]     e_waddr, e_raddr;
  logic [2*VB-1:0]   e_wdata, e_rdata;
  logic [SW-1:0]     s_waddr, s_raddr;
  logic [VB-1:0]     s_wdata, s_rdata;

  logic [VB-1:0]     ea, eb, other;
  logic              touch, hit, out_free, issue, scan_end;

  uet_ram #(.Width(2 * VB), .Depth(MAX_EDGES), .AddrW(IW)) u_edges (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .re_i(e_re), .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  uet_ram #(.Width(VB), .Depth(MAX_EDGES + 1), .AddrW(SW)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  function automatic res_t mk_res(logic [StatW-1:0] st, logic fnd, logic [IW-1:0] idx,
                                  logic [CW-1:0] deg, logic [CW-1:0] cnt,
                                  logic [VB-1:0] vtx);
    res_t r;
    r.status       = st;
    r.found        = fnd;
    r.edge_index   = IdxW'(idx);
    r.degree_count = CntW'(deg);
    r.edge_count   = CntW'(cnt);
    r.path_vertex  = VtxW'(vtx);
    return r;
  endfunction

  assign out_free = !ov_q || m_axis_tready_i;
  assign ea       = e_rdata[2*VB-1:VB];
  assign eb       = e_rdata[VB-1:0];
  assign scan_end = (scan_q >= held_q) && !rv_q;
  assign issue    = scan_q < held_q;

  always_comb begin
    other = '0;
    touch = 1'b0;
    if (top_q == ea) begin
      other = eb;
      touch = 1'b1;
    end else if (top_q == eb) begin
      other = ea;
      touch = 1'b1;
    end
  end
  assign hit = rv_q && !used_q[ridx_q] && touch && (other != '0);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    a_d     = a_q;
    b_d     = b_q;
    top_d   = top_q;
    held_d  = held_q;
    scan_d  = scan_q;
    deg_d   = deg_q;
    rv_d    = 1'b0;
    ridx_d  = ridx_q;
    mi_d    = mi_q;
    used_d  = used_q;
    depth_d = depth_q;
    k_d     = k_q;
    res_d   = res_q;
    out_d   = out_q;
    olast_d = olast_q;
    ov_d    = ov_q && !m_axis_tready_i;
    e_we = 1'b0; e_waddr = '0; e_wdata = '0;
    e_re = 1'b0; e_raddr = scan_q[IW-1:0];
    s_we = 1'b0; s_waddr = '0; s_wdata = '0;
    s_re = 1'b0; s_raddr = k_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = s_axis_tdata_i[2:0];
          a_d     = VB'(s_axis_tdata_i[10:3]);
          b_d     = VB'(s_axis_tdata_i[18:11]);
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        scan_d = '0;
        deg_d  = '0;
        case (cmd_q)
          CMD_ADD: begin
            state_d = S_RESP;
            if (held_q >= CW'(MAX_EDGES)) begin
              res_d = mk_res(ST_FULL, 1'b0, '0, '0, held_q, '0);
            end else begin
              e_we    = 1'b1;
              e_waddr = held_q[IW-1:0];
              e_wdata = {a_q, b_q};
              held_d  = held_q + 1'b1;
              res_d   = mk_res(ST_OK, 1'b0, '0, '0, held_q + 1'b1, '0);
            end
          end
          CMD_REMOVE, CMD_LOOKUP, CMD_DEGREE: state_d = S_SCAN;
          CMD_CLEAR: begin
            held_d  = '0;
            res_d   = mk_res(ST_OK, 1'b0, '0, '0, '0, '0);
            state_d = S_RESP;
          end
          CMD_PATH: begin
            if (b_q == '0) begin
              res_d   = mk_res(ST_OK, 1'b0, '0, '0, held_q, a_q);
              state_d = S_RESP;
            end else begin
              used_d  = '0;
              s_we    = 1'b1;
              s_waddr = '0;
              s_wdata = a_q;
              depth_d = DW'(1);
              top_d   = a_q;
              state_d = S_SCAN;
            end
          end
          default: begin
            res_d   = mk_res(ST_OK, 1'b0, '0, '0, held_q, '0);
            state_d = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        // one read issued per cycle, the previous one compared
        if (issue) begin
          e_re   = 1'b1;
          scan_d = scan_q + 1'b1;
          rv_d   = 1'b1;
          ridx_d = scan_q[IW-1:0];
        end
        case (cmd_q)
          CMD_LOOKUP, CMD_REMOVE: begin
            if (rv_q && (((ea == a_q) && (eb == b_q)) || ((ea == b_q) && (eb == a_q)))) begin
              mi_d = ridx_q;
              if (cmd_q == CMD_LOOKUP) begin
                res_d   = mk_res(ST_OK, 1'b1, ridx_q, '0, held_q, '0);
                state_d = S_RESP;
              end else begin
                scan_d  = CW'(ridx_q) + 1'b1;
                rv_d    = 1'b0;
                state_d = S_SHIFT;
              end
            end else if (scan_end) begin
              res_d   = mk_res(ST_NOTFOUND, 1'b0, '0, '0, held_q, '0);
              state_d = S_RESP;
            end
          end
          CMD_DEGREE: begin
            if (rv_q && ((ea == a_q) || (eb == a_q))) begin
              deg_d = deg_q + 1'b1;
            end
            if (scan_end) begin
              res_d   = mk_res(ST_OK, 1'b0, '0, deg_q, held_q, '0);
              state_d = S_RESP;
            end
          end
          default: begin
            if (hit) begin
              // push the far end, mark the edge, restart from entry 0
              used_d[ridx_q] = 1'b1;
              s_we    = 1'b1;
              s_waddr = depth_q[SW-1:0];
              s_wdata = other;
              depth_d = depth_q + 1'b1;
              top_d   = other;
              scan_d  = '0;
              rv_d    = 1'b0;
              if (other == b_q) begin
                k_d     = '0;
                state_d = S_EMRD;
              end
            end else if (scan_end) begin
              depth_d = depth_q - 1'b1;
              if (depth_q == DW'(1)) begin
                res_d   = mk_res(ST_NOPATH, 1'b0, '0, '0, held_q, '0);
                state_d = S_RESP;
              end else begin
                s_re    = 1'b1;
                s_raddr = SW'(depth_q - DW'(2));
                state_d = S_POP;
              end
            end
          end
        endcase
      end
      S_SHIFT: begin
        if (issue) begin
          e_re   = 1'b1;
          scan_d = scan_q + 1'b1;
          rv_d   = 1'b1;
          ridx_d = scan_q[IW-1:0];
        end
        if (rv_q) begin
          e_we    = 1'b1;
          e_waddr = ridx_q - 1'b1;
          e_wdata = e_rdata;
        end
        if (scan_end) begin
          held_d  = held_q - 1'b1;
          res_d   = mk_res(ST_OK, 1'b1, mi_q, '0, held_q - 1'b1, '0);
          state_d = S_RESP;
        end
      end
      S_POP: begin
        top_d   = s_rdata;
        scan_d  = '0;
        state_d = S_SCAN;
      end
      S_EMRD: begin
        s_re    = 1'b1;
        state_d = S_EMWR;
      end
      S_EMWR: begin
        if (out_free) begin
          ov_d    = 1'b1;
          out_d   = mk_res(ST_OK, 1'b0, '0, '0, held_q, s_rdata);
          olast_d = (DW'(k_q) + 1'b1) == depth_q;
          if (olast_d) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_EMRD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_d    = 1'b1;
          out_d   = res_q;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_q  <= '0;
      used_q  <= '0;
      depth_q <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      used_q  <= used_d;
      depth_q <= depth_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    a_q     <= a_d;
    b_q     <= b_d;
    top_q   <= top_d;
    scan_q  <= scan_d;
    deg_q   <= deg_d;
    ridx_q  <= ridx_d;
    mi_q    <= mi_d;
    k_q     <= k_d;
    res_q   <= res_d;
    out_q   <= out_d;
    olast_q <= olast_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {4'b0, out_q};
  assign m_axis_tlast_o  = olast_q;

  `UET_ASSERT(a_held_range, held_q <= CW'(MAX_EDGES), "edge count beyond table size")
  `UET_ASSERT(a_depth_range, depth_q <= DW'(MAX_EDGES + 1), "stack depth overflow")
  `UET_ASSERT_IMP(a_emit_in_stack, state_q == S_EMWR, (DW'(k_q) < depth_q),
                  "emit index past stack top")

endmodule

[bench/uetpf_checker.sv]
// Watches both stream channels of the edge table path finder, predicts each result word
// from the accepted commands and compares it field by field.
// Depends on uetpf_pkg.
module uetpf_checker
  import uetpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [23:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int unsigned TableDepth = 32;

  typedef struct {
    logic [StatW-1:0] status;
    logic             found;
    logic [IdxW-1:0]  edge_index;
    logic [CntW-1:0]  degree_count;
    logic [CntW-1:0]  edge_count;
    logic [VtxW-1:0]  path_vertex;
    logic             last;
  } word_t;

  logic [VtxW-1:0]       end_a [TableDepth];
  logic [VtxW-1:0]       end_b [TableDepth];
  int unsigned           held;
  logic [TableDepth-1:0] used;
  logic [VtxW-1:0]       trail [TableDepth+1];
  int unsigned           trail_depth;
  word_t                 expected_words[$];

  function automatic word_t make_word(logic [StatW-1:0] st, logic fnd, int unsigned idx,
                                      int unsigned deg, logic [VtxW-1:0] vtx, logic lst);
    word_t w;
    w.status       = st;
    w.found        = fnd;
    w.edge_index   = idx[IdxW-1:0];
    w.degree_count = deg[CntW-1:0];
    w.edge_count   = held[CntW-1:0];
    w.path_vertex  = vtx;
    w.last         = lst;
    return w;
  endfunction

  // Append one predicted word at the tail of the queue.
  task automatic expect_word(word_t w);
    expected_words = {expected_words, w};
  endtask

  function automatic int match_edge(logic [VtxW-1:0] a, logic [VtxW-1:0] b);
    for (int i = 0; i < held; i++) begin
      if ((end_a[i] == a && end_b[i] == b) || (end_a[i] == b && end_b[i] == a)) return i;
    end
    return -1;
  endfunction

  // Depth-first walk: take the first unused edge at the top vertex, else pop.
  task automatic walk_path(logic [VtxW-1:0] a, logic [VtxW-1:0] b);
    logic [VtxW-1:0] p;
    logic [VtxW-1:0] q;
    logic [VtxW-1:0] other;
    used        = '0;
    trail[0]    = a;
    trail_depth = 1;
    p           = '0;
    while (p != b) begin
      if (trail_depth == 0) begin
        expect_word(make_word(ST_NOPATH, 1'b0, 0, 0, '0, 1'b1));
        return;
      end
      q = trail[trail_depth-1];
      p = '0;
      for (int i = 0; i < held; i++) begin
        if (used[i]) continue;
        if (q == end_a[i]) other = end_b[i];
        else if (q == end_b[i]) other = end_a[i];
        else continue;
        if (other != '0) begin
          p       = other;
          used[i] = 1'b1;
          if (trail_depth < TableDepth + 1) begin
            trail[trail_depth] = p;
            trail_depth++;
          end
          break;
        end
      end
      if (p == '0) trail_depth--;
    end
    for (int k = 0; k < trail_depth; k++)
      expect_word(make_word(ST_OK, 1'b0, 0, 0, trail[k], k + 1 == trail_depth));
  endtask

  task automatic predict_command(logic [23:0] word);
    logic [CmdW-1:0] cmd;
    logic [VtxW-1:0] a;
    logic [VtxW-1:0] b;
    int              idx;
    int unsigned     deg;
    cmd = word[2:0];
    a   = word[10:3];
    b   = word[18:11];
    case (cmd)
      CMD_ADD: begin
        if (held >= TableDepth) begin
          expect_word(make_word(ST_FULL, 1'b0, 0, 0, '0, 1'b1));
        end else begin
          end_a[held] = a;
          end_b[held] = b;
          held++;
          expect_word(make_word(ST_OK, 1'b0, 0, 0, '0, 1'b1));
        end
      end
      CMD_REMOVE, CMD_LOOKUP: begin
        idx = match_edge(a, b);
        if (idx < 0) begin
          expect_word(make_word(ST_NOTFOUND, 1'b0, 0, 0, '0, 1'b1));
        end else begin
          if (cmd == CMD_REMOVE) begin
            for (int i = idx; i + 1 < held; i++) begin
              end_a[i] = end_a[i+1];
              end_b[i] = end_b[i+1];
            end
            held--;
          end
          expect_word(make_word(ST_OK, 1'b1, idx, 0, '0, 1'b1));
        end
      end
      CMD_DEGREE: begin
        deg = 0;
        for (int i = 0; i < held; i++) if (end_a[i] == a || end_b[i] == a) deg++;
        expect_word(make_word(ST_OK, 1'b0, 0, deg, '0, 1'b1));
      end
      CMD_CLEAR: begin
        held = 0;
        expect_word(make_word(ST_OK, 1'b0, 0, 0, '0, 1'b1));
      end
      CMD_PATH: begin
        if (b == '0) expect_word(make_word(ST_OK, 1'b0, 0, 0, a, 1'b1));
        else walk_path(a, b);
      end
      default: expect_word(make_word(ST_OK, 1'b0, 0, 0, '0, 1'b1));
    endcase
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    if (!rst_ni) begin
      held = 0;
      expected_words.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %h last %b",
                   $time, m_axis_tdata_i, m_axis_tlast_i);
          errors_o++;
        end else begin
          w = expected_words.pop_front();
          check_field("status",       w.status,       m_axis_tdata_i[1:0]);
          check_field("found",        w.found,        m_axis_tdata_i[2]);
          check_field("edge_index",   w.edge_index,   m_axis_tdata_i[7:3]);
          check_field("degree_count", w.degree_count, m_axis_tdata_i[13:8]);
          check_field("edge_count",   w.edge_count,   m_axis_tdata_i[19:14]);
          check_field("path_vertex",  w.path_vertex,  m_axis_tdata_i[27:20]);
          check_field("last",         w.last,         m_axis_tlast_i);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) predict_command(s_axis_tdata_i);
      pending_o = expected_words.size();
    end
  end

endmodule

[bench/testbench.sv]
// Stimulus and verdict for the edge table path finder: directed commands, then random
// table builds, chains and queries with random gaps on both channels. Uses uetpf_checker.
module testbench;
  import uetpf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  int          errors;
  int          pending;
  bit          sink_steady;

  undirected_edge_table_path_finder_unit DUT (.*);

  uetpf_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tlast_i(m_axis_tlast_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("undirected_edge_table_path_finder_unit verification failed");
    $finish;
  end

  // Send one command word, after a random gap unless steady; hold valid until taken.
  task automatic send(logic [CmdW-1:0] cmd, logic [VtxW-1:0] a, logic [VtxW-1:0] b,
                      bit steady = 1'b0);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, b, a, cmd};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Mostly a handful of ids so paths and matches occur; sometimes zero or any id.
  function automatic logic [VtxW-1:0] pick_vertex();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return VtxW'($urandom_range(0, 255));
    return VtxW'($urandom_range(1, 7));
  endfunction

  // Sink: random stalls per word, with stall-free stretches.
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_steady = ~sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  initial begin
    int          sent;
    int          mode;
    bit          steady;
    logic [VtxW-1:0] base;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    rst_ni          = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, both orders, misses, zero ends, empty stack, unknown codes.
    send(CMD_PATH,   8'd1,   8'd2);
    send(CMD_ADD,    8'd255, 8'd0);
    send(CMD_ADD,    8'd1,   8'd255);
    send(CMD_ADD,    8'd1,   8'd255);
    send(CMD_ADD,    8'd0,   8'd1);
    send(CMD_LOOKUP, 8'd255, 8'd1);
    send(CMD_LOOKUP, 8'd0,   8'd255);
    send(CMD_LOOKUP, 8'd3,   8'd4);
    send(CMD_DEGREE, 8'd255, 8'd0);
    send(CMD_DEGREE, 8'd0,   8'd0);
    send(CMD_PATH,   8'd1,   8'd0);
    send(CMD_PATH,   8'd0,   8'd1);
    send(CMD_PATH,   8'd1,   8'd255);
    send(CMD_PATH,   8'd255, 8'd7);
    send(3'd6,       8'd170, 8'd85);
    send(3'd7,       8'd85,  8'd170);
    send(CMD_REMOVE, 8'd255, 8'd1);
    send(CMD_REMOVE, 8'd9,   8'd9);
    send(CMD_LOOKUP, 8'd1,   8'd255);
    send(CMD_CLEAR,  8'd0,   8'd0);
    send(CMD_DEGREE, 8'd1,   8'd0);
    sent = 21;

    // Random blocks: table builds with queries, long chains, and loose noise.
    while (sent < 470) begin
      mode   = $urandom_range(0, 9);
      steady = ($urandom_range(0, 3) == 0);
      if (mode == 0) begin
        // Chain of every slot, then an add on a full table and the longest path both ways.
        base = VtxW'($urandom_range(1, 200));
        send(CMD_CLEAR, '0, '0, steady);
        for (int i = 0; i < 32; i++)
          send(CMD_ADD, VtxW'(base + i), VtxW'(base + i + 1), steady);
        send(CMD_ADD, pick_vertex(), pick_vertex(), steady);
        send(CMD_PATH, base, VtxW'(base + 32), steady);
        send(CMD_PATH, VtxW'(base + 32), base, steady);
        sent += 36;
      end else if (mode < 7) begin
        if ($urandom_range(0, 2) == 0) begin
          send(CMD_CLEAR, pick_vertex(), pick_vertex(), steady);
          sent++;
        end
        repeat ($urandom_range(3, 12)) begin
          send(CMD_ADD, pick_vertex(), pick_vertex(), steady);
          sent++;
        end
        repeat ($urandom_range(2, 6)) begin
          case ($urandom_range(0, 4))
            0:       send(CMD_REMOVE, pick_vertex(), pick_vertex(), steady);
            1:       send(CMD_LOOKUP, pick_vertex(), pick_vertex(), steady);
            2:       send(CMD_DEGREE, pick_vertex(), pick_vertex(), steady);
            default: send(CMD_PATH,   pick_vertex(), pick_vertex(), steady);
          endcase
          sent++;
        end
      end else begin
        repeat ($urandom_range(2, 6)) begin
          send(CmdW'($urandom_range(0, 7)), VtxW'($urandom_range(0, 255)),
               VtxW'($urandom_range(0, 255)), steady);
          sent++;
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("undirected_edge_table_path_finder_unit verification clean");
    end else begin
      $display("undirected_edge_table_path_finder_unit verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/uetpf_pkg.sv
design/uet_ram.sv
design/undirected_edge_table_path_finder_unit.sv
bench/uetpf_checker.sv
bench/testbench.sv
